@@ rtl/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

	localparam int COLUMNS_DEFAULT = 80;
	localparam int ROWS_DEFAULT    = 25;

	localparam logic [7:0] RESET_COLOR  = 8'd10;
	localparam logic [7:0] BLANK_CODE   = 8'h20;
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;

	// item kinds carried in s_tuser
	localparam logic [1:0] MODE_PUT   = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	// result item, cursor_row in the lowest bits
	typedef struct packed {
		logic [15:0] cell_word;
		logic        did_scroll;
		logic [6:0]  cursor_column;
		logic [4:0]  cursor_row;
	} result_t;

	// sequencer status toward the top level
	typedef struct packed {
		logic busy;
		logic copy_write;
		logic fill_write;
		logic char_write;
	} ctrl_status_t;

endpackage

`default_nettype wire

@@ rtl/tcw_cell_ram.sv @@
`default_nettype none

module tcw_cell_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  wire          clk,
	input  wire          we,
	input  wire [AW-1:0] waddr,
	input  wire [15:0]   wdata,
	input  wire [AW-1:0] raddr,
	output logic [15:0]  rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
`default_nettype none

module tcw_ctrl #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT,
	parameter int AW      = $clog2(COLUMNS * ROWS)
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_wr_en,
	input  wire [7:0]             cfg_wr_data,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire [1:0]             in_mode,
	input  wire [7:0]             in_char,
	input  wire [10:0]            in_index,
	input  wire                   res_ready,
	output logic                  res_valid,
	output tcw_pkg::result_t      res,
	output tcw_pkg::ctrl_status_t status,
	output logic                  mem_we,
	output logic [AW-1:0]         mem_waddr,
	output logic [15:0]           mem_wdata,
	output logic [AW-1:0]         mem_raddr,
	input  wire [15:0]            mem_rdata
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int COPY_LEN   = COLUMNS * (ROWS - 1);
	localparam int CW         = $clog2(COLUMNS);
	localparam int RW         = $clog2(ROWS);

	typedef enum logic [5:0] {
		ST_INIT = 6'b000001,
		ST_IDLE = 6'b000010,
		ST_READ = 6'b000100,
		ST_COPY = 6'b001000,
		ST_FILL = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t          state_q;
	logic [RW-1:0]   row_q;
	logic [CW-1:0]   col_q;
	logic [AW-1:0]   pos_q;
	logic [AW-1:0]   ptr_q;
	logic [7:0]      color_q;
	logic [15:0]     fill_q;
	logic            scroll_q;
	logic            rd_ok_q;
	logic            wr_valid_s1;
	logic [AW-1:0]   wr_addr_s1;

	logic            accept;
	logic            is_nl;
	logic            row_adv;
	logic            scroll_now;
	logic [RW-1:0]   put_row;
	logic [CW-1:0]   put_col;
	logic [AW-1:0]   put_pos;
	logic            copy_wr;
	logic            fill_wr;
	logic            char_wr;
	logic [15:0]     blank_word;

	assign in_ready = (state_q == ST_IDLE) && res_ready;
	assign accept   = in_valid && in_ready;

	// cursor advance for a put
	assign is_nl      = (in_char == tcw_pkg::NEWLINE_CODE);
	assign row_adv    = is_nl || (col_q == CW'(COLUMNS - 1));
	assign scroll_now = row_adv && (row_q == RW'(ROWS - 1));
	assign put_col    = row_adv ? '0 : col_q + 1'b1;
	assign put_row    = (row_adv && !scroll_now) ? row_q + 1'b1 : row_q;

	always_comb begin
		if (scroll_now) begin
			put_pos = AW'(COPY_LEN);
		end else if (is_nl) begin
			put_pos = pos_q - AW'(col_q) + AW'(COLUMNS);
		end else begin
			put_pos = pos_q + 1'b1;
		end
	end

	assign blank_word = {color_q, tcw_pkg::BLANK_CODE};

	// single write port: pending copy, then fill sweep, then character
	assign copy_wr = wr_valid_s1;
	assign fill_wr = (state_q == ST_INIT) || ((state_q == ST_FILL) && !wr_valid_s1);
	assign char_wr = accept && (in_mode == tcw_pkg::MODE_PUT) && !is_nl;

	always_comb begin
		mem_we    = copy_wr || fill_wr || char_wr;
		mem_waddr = pos_q;
		mem_wdata = {color_q, in_char};
		if (copy_wr) begin
			mem_waddr = wr_addr_s1;
			mem_wdata = mem_rdata;
		end else if (state_q == ST_INIT) begin
			mem_waddr = ptr_q;
			mem_wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::BLANK_CODE};
		end else if (fill_wr) begin
			mem_waddr = ptr_q;
			mem_wdata = fill_q;
		end
	end

	assign mem_raddr = (state_q == ST_COPY) ? ptr_q + AW'(COLUMNS) : AW'(in_index);

	always_comb begin
		res_valid           = 1'b0;
		res.cursor_row      = 5'(row_q);
		res.cursor_column   = 7'(col_q);
		res.did_scroll      = 1'b0;
		res.cell_word       = '0;
		unique case (state_q) inside
			ST_IDLE: begin
				if (accept) begin
					case (in_mode) inside
						tcw_pkg::MODE_PUT: begin
							res_valid         = !scroll_now;
							res.cursor_row    = 5'(put_row);
							res.cursor_column = 7'(put_col);
						end
						tcw_pkg::MODE_CLEAR, tcw_pkg::MODE_READ: res_valid = 1'b0;
						default: res_valid = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				res_valid     = 1'b1;
				res.cell_word = rd_ok_q ? mem_rdata : '0;
			end
			ST_DONE: begin
				res_valid      = res_ready;
				res.did_scroll = scroll_q;
			end
			ST_INIT, ST_COPY, ST_FILL: res_valid = 1'b0;
			default: res_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			row_q       <= '0;
			col_q       <= '0;
			pos_q       <= '0;
			ptr_q       <= '0;
			color_q     <= tcw_pkg::RESET_COLOR;
			wr_valid_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				color_q <= cfg_wr_data;
			end
			wr_valid_s1 <= (state_q == ST_COPY);
			unique case (state_q)
				ST_INIT: begin
					if (ptr_q == AW'(CELL_COUNT - 1)) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						ptr_q <= '0;
						case (in_mode)
							tcw_pkg::MODE_PUT: begin
								row_q <= put_row;
								col_q <= put_col;
								pos_q <= put_pos;
								if (scroll_now) begin
									state_q <= ST_COPY;
								end
							end
							tcw_pkg::MODE_CLEAR: begin
								row_q   <= '0;
								col_q   <= '0;
								pos_q   <= '0;
								state_q <= ST_FILL;
							end
							tcw_pkg::MODE_READ: state_q <= ST_READ;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_READ: state_q <= ST_IDLE;
				ST_COPY: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == AW'(COPY_LEN - 1)) begin
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (!wr_valid_s1) begin
						if (ptr_q == AW'(CELL_COUNT - 1)) begin
							state_q <= ST_DONE;
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		wr_addr_s1 <= ptr_q;
		if (accept) begin
			fill_q   <= blank_word;
			scroll_q <= (in_mode == tcw_pkg::MODE_PUT) && scroll_now;
			rd_ok_q  <= (32'(in_index) < CELL_COUNT);
		end
	end

	assign status.busy       = (state_q != ST_IDLE);
	assign status.copy_write = copy_wr;
	assign status.fill_write = fill_wr;
	assign status.char_write = char_wr;

endmodule

`default_nettype wire

@@ rtl/text_console_writer.sv @@
// text console writer: a ROWS x COLUMNS character-cell screen with cursor and scroll
//
// s_* channel takes one item per handshake (s_tvalid & s_tready); s_tuser holds
// the item kind: put character, clear screen, or read one cell.
// m_* channel returns exactly one result item per input item, in order.
// cfg_wr_en / cfg_wr_data set the attribute byte used for written and blanked cells.
//
// a plain put or an unused kind shows on m_tvalid in the cycle after acceptance,
// and a put that causes no scroll can be accepted every cycle while m_tready is high;
// a read goes through the synchronous cell memory read port, then the output register.
// a put that scrolls walks the memory: one copy per cycle for COLUMNS*(ROWS-1)
// cells, a drain step for the last copy, then COLUMNS blanking writes; a clear
// blanks all ROWS*COLUMNS cells. the single memory write port makes these sweeps serial.
//
// after reset the block blanks all ROWS*COLUMNS cells with s_tready low;
// configuration writes are still taken then.
// a stalled receiver holds the result in the output register; the next item
// is taken as soon as that register is free or being emptied in the same cycle.

`default_nettype none

module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
	input  wire         clk,
	input  wire         arst_n,
	// configuration: text_color
	input  wire         cfg_wr_en,
	input  wire [7:0]   cfg_wr_data,
	// input items
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [23:0]  s_tdata,   // char_code[7:0], cell_index[18:8], zero pad
	input  wire [1:0]   s_tuser,   // mode[1:0]
	// result items
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata    // cursor_row[4:0], cursor_column[11:5],
	                               // did_scroll[12], cell_word[28:13], zero pad
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int AW         = $clog2(CELL_COUNT);

	logic                  res_ready;
	logic                  res_valid;
	tcw_pkg::result_t      res;
	tcw_pkg::ctrl_status_t status;

	// output register between the sequencer and the receiver
	logic                  m_tvalid_q;
	tcw_pkg::result_t      m_res_q;

	// cell memory port
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [15:0]           mem_wdata;
	logic [AW-1:0]         mem_raddr;
	logic [15:0]           mem_rdata;

	tcw_ctrl #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.AW      (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_mode     (s_tuser),
		.in_char     (s_tdata[7:0]),
		.in_index    (s_tdata[18:8]),
		.res_ready   (res_ready),
		.res_valid   (res_valid),
		.res         (res),
		.status      (status),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	tcw_cell_ram #(
		.DEPTH (CELL_COUNT),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// slot is free when empty or drained this cycle
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, m_res_q};

`ifndef SYNTHESIS
	// only one writer may own the memory write port in a cycle
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({status.copy_write, status.fill_write, status.char_write}))
		else $error("cell memory write port claimed twice");

	// no item taken while a sweep, read or pending result is in progress
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		status.busy |-> !s_tready)
		else $error("item accepted while sequencer busy");

	// a new result never overwrites one the receiver has not taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_ready)
		else $error("result overruns output register");

	// a scroll always leaves the cursor at the start of the last row; only its column is checked
	a_scroll_home: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.did_scroll) |-> (res.cursor_column == 7'd0))
		else $error("scroll left cursor off column zero");
`endif

endmodule

`default_nettype wire

@@ verif/text_console_writer_tb.sv @@
`default_nettype none

module text_console_writer_tb;
	import tcw_pkg::*;

	localparam int COLUMNS    = COLUMNS_DEFAULT;
	localparam int ROWS       = ROWS_DEFAULT;
	localparam int CELL_COUNT = COLUMNS * ROWS;

	// the fourth item kind has no meaning and must leave the screen alone
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// scroll and clear sweep all ROWS*COLUMNS cells, so this is many times the longest gap
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int PHASE_COUNT     = 5;
	localparam int ITEMS_PER_PHASE = 130;
	localparam int REPORT_LIMIT    = 10;

	// screen contents, cursor and color as the block should hold them, plus the
	// queue of results still owed by the block
	class screen_scoreboard;
		logic [15:0] cells [CELL_COUNT];
		int          row;
		int          col;
		logic [7:0]  color;
		result_t     expected_results [$];
		int          errors;
		int          checked;

		function new();
			color   = RESET_COLOR;
			errors  = 0;
			checked = 0;
			blank_screen();
		endfunction

		function logic [15:0] blank_word();
			return {color, BLANK_CODE};
		endfunction

		function void blank_screen();
			for (int i = 0; i < CELL_COUNT; i++)
				cells[i] = blank_word();
			row = 0;
			col = 0;
		endfunction

		// all rows move up by one, the bottom row gets blanks in the current color
		function void scroll_up();
			for (int i = 0; i < COLUMNS * (ROWS - 1); i++)
				cells[i] = cells[i + COLUMNS];
			for (int i = 0; i < COLUMNS; i++)
				cells[(ROWS - 1) * COLUMNS + i] = blank_word();
		endfunction

		function result_t console_step(logic [1:0] mode, logic [7:0] char_code,
		                               logic [10:0] cell_index);
			result_t r;
			r = '0;
			case (mode)
				MODE_PUT: begin
					if (char_code == NEWLINE_CODE) begin
						col = 0;
						row++;
					end else begin
						cells[row * COLUMNS + col] = {color, char_code};
						col++;
						if (col >= COLUMNS) begin
							col = 0;
							row++;
						end
					end
					if (row >= ROWS) begin
						scroll_up();
						row          = ROWS - 1;
						r.did_scroll = 1'b1;
					end
				end
				MODE_CLEAR: blank_screen();
				MODE_READ: begin
					if (cell_index < CELL_COUNT)
						r.cell_word = cells[cell_index];
				end
				default: ;
			endcase
			r.cursor_row    = row[4:0];
			r.cursor_column = col[6:0];
			return r;
		endfunction

		function void note_item(logic [1:0] mode, logic [7:0] char_code,
		                        logic [10:0] cell_index);
			expected_results.push_back(console_step(mode, char_code, cell_index));
		endfunction

		function void report_field(string name, int want, int got);
			if (want != got) begin
				if (errors < REPORT_LIMIT)
					$display("result %0d %s: expected 0x%0h, got 0x%0h",
					         checked, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [31:0] word);
			result_t got;
			result_t want;
			got = result_t'(word[28:0]);
			if (expected_results.size() == 0) begin
				if (errors < REPORT_LIMIT)
					$display("result %0d arrived with no item outstanding: 0x%0h",
					         checked, word);
				errors++;
			end else begin
				want = expected_results.pop_front();
				report_field("cursor_row", want.cursor_row, got.cursor_row);
				report_field("cursor_column", want.cursor_column, got.cursor_column);
				report_field("did_scroll", want.did_scroll, got.did_scroll);
				report_field("cell_word", want.cell_word, got.cell_word);
			end
			checked++;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [7:0]  cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;     // char_code[7:0], cell_index[18:8], zero pad
	logic [1:0]  s_tuser;     // mode[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;     // cursor_row[4:0], cursor_column[11:5], did_scroll[12],
	                          // cell_word[28:13], zero pad

	screen_scoreboard sb;
	bit               sender_fast;
	int               idle_cycles = 0;

	text_console_writer #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	always #6 clk = ~clk;

	// ends the run when neither side has moved an item for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: random stalls counted in cycles, with runs of full throughput
	initial begin : result_sink
		int stall;
		stall = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata);
				// about one result in five goes through with no stall
				stall = (sb.checked % 100 < 20) ? 0 : $urandom_range(0, 16);
			end else if (stall > 0) begin
				stall--;
			end
			m_tready <= (stall == 0);
		end
	end

	// one input item; valid stays high across back-to-back items
	task automatic send_item(input logic [1:0] mode, input logic [7:0] char_code,
	                         input logic [10:0] cell_index);
		int gap;
		gap = sender_fast ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {5'd0, cell_index, char_code};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_item(mode, char_code, cell_index);
	endtask

	// hold the sender until every result is back, then let the block settle
	task automatic wait_until_drained();
		s_tvalid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// random bursts: text runs, full lines that wrap, newline runs that scroll,
	// reads near the cursor, and the odd clear or unused item
	task automatic run_phase(input int count);
		int          made;
		int          kind;
		int          len;
		int          r;
		logic [7:0]  ch;
		logic [10:0] idx;
		made = 0;
		while (made < count) begin
			kind        = $urandom_range(0, 99);
			sender_fast = ($urandom_range(0, 3) == 0);
			if (kind < 30) begin
				len = $urandom_range(1, 40);
				if (len > count - made)
					len = count - made;
				for (int i = 0; i < len; i++) begin
					ch = ($urandom_range(0, 7) == 0) ? NEWLINE_CODE : 8'($urandom_range(0, 255));
					send_item(MODE_PUT, ch, 11'($urandom_range(0, 2047)));
				end
			end else if (kind < 45) begin
				// plain characters, about a line's worth, so runs usually reach the line end
				len = $urandom_range(75, 90);
				if (len > count - made)
					len = count - made;
				for (int i = 0; i < len; i++) begin
					ch = 8'($urandom_range(0, 254));
					if (ch >= NEWLINE_CODE)
						ch = ch + 8'd1;
					send_item(MODE_PUT, ch, 11'd0);
				end
			end else if (kind < 65) begin
				len = $urandom_range(1, 30);
				if (len > count - made)
					len = count - made;
				for (int i = 0; i < len; i++)
					send_item(MODE_PUT, NEWLINE_CODE, 11'd0);
			end else if (kind < 90) begin
				len = $urandom_range(1, 8);
				if (len > count - made)
					len = count - made;
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 1) == 0) begin
						r = sb.row - $urandom_range(0, 1);
						if (r < 0)
							r = 0;
						idx = 11'(r * COLUMNS + $urandom_range(0, COLUMNS - 1));
					end else begin
						idx = 11'($urandom_range(0, 2047));
					end
					send_item(MODE_READ, 8'($urandom_range(0, 255)), idx);
				end
			end else if (kind < 96) begin
				len = 1;
				send_item(MODE_UNUSED, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
			end else begin
				len = 1;
				send_item(MODE_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
			end
			made += len;
		end
	endtask

	initial begin : stimulus
		logic [7:0] color;
		sb = new();
		sender_fast = 1'b0;
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= 8'd0;
		s_tvalid    <= 1'b0;
		s_tdata     <= 24'd0;
		s_tuser     <= MODE_PUT;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset screen contents, corners and reads past the end
		send_item(MODE_READ, 8'h00, 11'd0);
		send_item(MODE_READ, 8'hFF, 11'(CELL_COUNT - 1));
		send_item(MODE_READ, 8'h00, 11'(CELL_COUNT));
		send_item(MODE_READ, 8'h00, 11'd2047);
		// unused kind leaves everything as it is
		send_item(MODE_UNUSED, 8'hFF, 11'd2047);
		// character zero is stored like any other
		send_item(MODE_PUT, 8'h00, 11'd0);
		send_item(MODE_PUT, 8'hFF, 11'd2047);
		send_item(MODE_PUT, 8'h80, 11'd0);
		send_item(MODE_PUT, 8'h7F, 11'd0);
		send_item(MODE_READ, 8'h00, 11'd0);
		send_item(MODE_READ, 8'h00, 11'd1);
		send_item(MODE_READ, 8'h00, 11'd2);
		send_item(MODE_READ, 8'h00, 11'd3);
		send_item(MODE_PUT, NEWLINE_CODE, 11'd0);
		send_item(MODE_PUT, 8'h41, 11'd0);
		send_item(MODE_READ, 8'h00, 11'(COLUMNS));
		send_item(MODE_CLEAR, 8'h00, 11'd0);
		send_item(MODE_READ, 8'h00, 11'd0);
		send_item(MODE_READ, 8'h00, 11'(COLUMNS));

		// each phase runs under its own color, extremes first
		for (int p = 0; p < PHASE_COUNT; p++) begin
			wait_until_drained();
			case (p)
				0:       color = 8'h00;
				1:       color = 8'hFF;
				4:       color = 8'h80;
				default: color = 8'($urandom_range(0, 255));
			endcase
			cfg_wr_en   <= 1'b1;
			cfg_wr_data <= color;
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			sb.color = color;
			run_phase(ITEMS_PER_PHASE);
		end

		wait_until_drained();
		repeat (16) @(posedge clk);
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
